[src/wprm_pkg.sv]
`default_nettype none

package wprm_pkg;

  localparam int DEPTH      = 4;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PERIOD_W   = 18;
  localparam int SLOT_W     = 17;
  localparam int SUM_W      = 23;
  localparam int RPM_W      = 32;
  localparam int FREQ_W     = 32;
  // divisor is 60 * sum: sum * 64 - sum * 4
  localparam int DIVISOR_W  = SUM_W + 6;
  localparam int STEP_CNT_W = $clog2(RPM_W);

  localparam logic [PERIOD_W-1:0] OVERFLOW_LIMIT = PERIOD_W'(131070);
  localparam logic [RPM_W-1:0]    RPM_ALL_ONES   = '1;
  localparam logic [FREQ_W-1:0]   FREQ_RESET     = FREQ_W'(1000000);

  localparam logic [IDX_W-1:0]    LAST_IDX       = IDX_W'(DEPTH - 1);

  // register word index on the config port
  localparam logic [0:0] REG_TIMER_FREQ = 1'b0;

  typedef struct packed {
    logic             captured;
    logic [SUM_W-1:0] sum;
  } win_stat_t;

endpackage

`default_nettype wire

[src/wprm_window.sv]
`default_nettype none

module wprm_window (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire [wprm_pkg::PERIOD_W-1:0] period,
  output logic                         need_div,
  output wprm_pkg::win_stat_t          stat
);
  import wprm_pkg::*;

  logic [SLOT_W-1:0] ring_r [DEPTH];
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic              captured_r;
  logic              overflow;
  logic [SLOT_W-1:0] slot_new;

  assign overflow = (period >= OVERFLOW_LIMIT);
  assign slot_new = period[SLOT_W-1:0];
  assign idx_nxt  = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
  // running sum: drop the slot being overwritten, add the new one
  assign sum_nxt  = sum_r - SUM_W'(ring_r[idx_r]) + SUM_W'(slot_new);
  assign need_div = wr_en && !overflow && captured_r;

  assign stat.captured = captured_r;
  assign stat.sum      = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) ring_r[k] <= '0;
      idx_r      <= '0;
      sum_r      <= '0;
      captured_r <= 1'b0;
    end else if (wr_en) begin
      if (overflow) begin
        for (int k = 0; k < DEPTH; k++) ring_r[k] <= '0;
        idx_r      <= '0;
        sum_r      <= '0;
        captured_r <= 1'b0;
      end else begin
        ring_r[idx_r] <= slot_new;
        idx_r         <= idx_nxt;
        sum_r         <= sum_nxt;
        if (idx_nxt == '0) captured_r <= 1'b1;
      end
    end
  end

  a_overflow_clears: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && overflow |=> sum_r == '0 && !captured_r && idx_r == '0)
    else $error("overflow period did not clear the window");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("ring index out of range");

endmodule

`default_nettype wire

[src/wprm_divider.sv]
`default_nettype none

module wprm_divider (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [wprm_pkg::FREQ_W-1:0] dividend,
  input  wire [wprm_pkg::SUM_W-1:0]  sum,
  output logic                       busy,
  output logic                       done,
  output logic [wprm_pkg::RPM_W-1:0] quotient
);
  import wprm_pkg::*;

  logic [DIVISOR_W-1:0]  d_r;
  logic [DIVISOR_W-1:0]  d_start;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [RPM_W-1:0]      q_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  q_bit;

  // floor(floor(f / s) / 60) == floor(f / (60 * s))
  assign d_start = (DIVISOR_W'(sum) << 6) - (DIVISOR_W'(sum) << 2);

  // one quotient bit per cycle, dividend bits shift out of q_r as quotient bits shift in
  assign shifted = {rem_r, q_r[RPM_W-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign q_bit   = !diff[DIVISOR_W];
  assign rem_nxt = q_bit ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_CNT_W'(1);
        if (cnt_r == STEP_CNT_W'(RPM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= d_start;
      rem_r <= '0;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[RPM_W-2:0], q_bit};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r && sum != '0)
    else $error("divider started while busy or with zero divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished pass");

endmodule

`default_nettype wire

[src/windowed_period_rpm_meter.sv]
`default_nettype none

// channel  | direction | payload                         | handshake
// in_      | slave     | tdata[17:0] period_ticks        | tvalid / tready
// out_     | master    | tdata[31:0] rpm_value,          | tvalid / tready
//          |           | tuser[0] is_captured            |
// cfg_     | apb slave | word 0: timer_frequency_hz      | psel / penable, pready high
//
// a beat that is an overflow, that finds the window not yet captured (the beat that
// completes the first fill included) or that finds a zero window sum goes from ST_EVAL
// straight to ST_DONE; a captured beat with a nonzero sum runs the bit-serial divider
// in ST_DIV between ST_EVAL and ST_DONE
// only one beat is in work at a time; the next beat is taken while a result waits in the
// output register, and a finished beat stalls until that register is free
// rst_n is synchronous: window, rpm and handshakes are cleared, the frequency register goes to 1000000

module windowed_period_rpm_meter (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // [17:0] period_ticks, rest zero

  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] rpm_value
  output logic [0:0]  out_tuser,  // [0] is_captured

  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [1:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import wprm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [FREQ_W-1:0] freq_r;
  logic [RPM_W-1:0]  rpm_r;
  logic              need_div_r;
  logic              out_valid_r;
  logic [RPM_W-1:0]  out_rpm_r;
  logic              out_cap_r;

  logic              in_beat;
  logic              need_div;
  win_stat_t         win_stat;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [RPM_W-1:0]  div_q;
  logic              out_free;
  logic              cfg_wr;

  // config port: single word, the address is ignored on reads and writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[1] == REG_TIMER_FREQ) ? freq_r : freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) freq_r <= FREQ_RESET;
    else if (cfg_wr) freq_r <= cfg_pwdata;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  wprm_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_beat),
    .period   (in_tdata[PERIOD_W-1:0]),
    .need_div (need_div),
    .stat     (win_stat)
  );

  // sum is settled in the cycle after the beat; zero sum saturates without dividing
  assign div_start = (state_r == ST_EVAL) && need_div_r && (win_stat.sum != '0);

  wprm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (freq_r),
    .sum      (win_stat.sum),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_beat) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = div_start ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      need_div_r  <= 1'b0;
      rpm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_beat) need_div_r <= need_div;
      if (state_r == ST_EVAL && need_div_r && win_stat.sum == '0) rpm_r <= RPM_ALL_ONES;
      if (state_r == ST_DIV && div_done) rpm_r <= div_q;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // result payload: rpm only once the window is captured
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_rpm_r <= win_stat.captured ? rpm_r : RPM_ALL_ONES;
      out_cap_r <= win_stat.captured;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rpm_r;
  assign out_tuser  = out_cap_r;

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> div_busy || div_done)
    else $error("waiting on divider that is not running");

  a_div_only_captured: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> win_stat.captured)
    else $error("division started before window capture");

endmodule

`default_nettype wire

[test/windowed_period_rpm_meter_tb.sv]
`timescale 1ns / 100ps

module windowed_period_rpm_meter_tb;
  import wprm_pkg::*;

  localparam int          HALF_PERIOD     = 4;
  localparam int          RESET_CYCLES    = 9;
  // cycles without any beat on either channel before the run is called hung
  localparam int          STALL_LIMIT     = 3000;
  // extra wait at the end, enough to cover the tail of a captured beat that runs the divider
  localparam int          TAIL_CYCLES     = 40;
  localparam int          RANDOM_PER_PASS = 175;
  localparam int unsigned SEC_PER_MIN     = 60;
  localparam logic [1:0]  FREQ_ADDR       = 2'(4 * int'(REG_TIMER_FREQ));
  localparam logic [PERIOD_W-1:0] LONGEST_VALID = OVERFLOW_LIMIT - 1'b1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX    = '1;
  localparam logic [FREQ_W-1:0]   FREQ_MAX      = '1;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             captured;
  } rpm_beat_t;

  // tracks the period window and keeps the rpm results still owed by the block
  class tach_tracker;
    logic [SLOT_W-1:0] slot[DEPTH];
    logic [5:0]        slot_pos;
    logic [SUM_W-1:0]  window_total;
    logic              window_full;
    logic [RPM_W-1:0]  rpm_reg;
    logic [FREQ_W-1:0] freq_hz;
    rpm_beat_t         owed_rpm[$];
    int                errors;

    function new();
      clear_window();
      rpm_reg = '0;
      freq_hz = FREQ_RESET;
      errors  = 0;
    endfunction

    function void clear_window();
      foreach (slot[k]) slot[k] = '0;
      slot_pos     = '0;
      window_total = '0;
      window_full  = 1'b0;
    endfunction

    function void set_frequency(logic [FREQ_W-1:0] hz);
      freq_hz = hz;
    endfunction

    function int pending();
      return owed_rpm.size();
    endfunction

    function void note_period(logic [PERIOD_W-1:0] ticks);
      logic [SUM_W-1:0] acc;
      rpm_beat_t        beat;
      if (ticks < OVERFLOW_LIMIT) begin
        if (slot_pos >= DEPTH) slot_pos = '0;
        slot[slot_pos] = ticks[SLOT_W-1:0];
        slot_pos = (slot_pos + 1 >= DEPTH) ? 6'd0 : slot_pos + 6'd1;
        if (window_full) begin
          acc = '0;
          foreach (slot[k]) acc += SUM_W'(slot[k]);
          window_total = acc;
          if (window_total == '0) rpm_reg = RPM_ALL_ONES;
          else rpm_reg = (freq_hz / FREQ_W'(window_total)) / RPM_W'(SEC_PER_MIN);
        end else if (slot_pos == '0) begin
          // first fill done: flag set, rpm register keeps its old value
          window_full = 1'b1;
        end
      end else begin
        clear_window();
      end
      beat.rpm      = window_full ? rpm_reg : RPM_ALL_ONES;
      beat.captured = window_full;
      owed_rpm.push_back(beat);
    endfunction

    function void check_result(logic [RPM_W-1:0] rpm_got, logic captured_got);
      rpm_beat_t want;
      if (owed_rpm.size() == 0) begin
        $display("%0t: result with none expected, rpm %0d captured %0b",
                 $time, rpm_got, captured_got);
        errors++;
        return;
      end
      want = owed_rpm.pop_front();
      if (rpm_got !== want.rpm) begin
        $display("%0t: rpm_value mismatch, expected %0d actual %0d",
                 $time, want.rpm, rpm_got);
        errors++;
      end
      if (captured_got !== want.captured) begin
        $display("%0t: is_captured mismatch, expected %0b actual %0b",
                 $time, want.captured, captured_got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // [17:0] period_ticks, rest zero

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] rpm_value
  logic [0:0]  out_tuser;         // [0] is_captured

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tach_tracker tracker = new();

  // percent of cycles in which each side holds back
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles  = 0;

  windowed_period_rpm_meter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // result side: check every accepted beat, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tdata[RPM_W-1:0], out_tuser[0]);
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on handshake activity, not on total run length
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one period beat; returns at the edge where it was taken
  task automatic send_period(input logic [PERIOD_W-1:0] ticks);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 24'(ticks);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_period(ticks);
  endtask

  // every beat yields one result, so an empty queue means the block is idle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // apb write: setup then access, done at the edge with pready high
  task automatic write_frequency(input logic [FREQ_W-1:0] hz);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= FREQ_ADDR;
    cfg_pwdata  <= hz;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.set_frequency(hz);
  endtask

  // mostly valid periods, with overflows often enough to restart the window
  function automatic logic [PERIOD_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return PERIOD_W'($urandom_range(int'(OVERFLOW_LIMIT), int'(PERIOD_MAX)));
    if (roll < 10) return '0;
    if (roll < 35) return PERIOD_W'($urandom_range(1, 64));
    if (roll < 42) return LONGEST_VALID - PERIOD_W'($urandom_range(0, 3));
    return PERIOD_W'($urandom_range(0, int'(LONGEST_VALID)));
  endfunction

  task automatic random_pass(input int count);
    repeat (count) send_period(pick_period());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 17;
    recv_idle_pct = 78;

    // all-zero window: fill completes with rpm 0, then the sum saturates
    repeat (5) send_period('0);
    // longest valid periods everywhere
    repeat (4) send_period(LONGEST_VALID);
    // overflow values, all bits of the field set included
    send_period(OVERFLOW_LIMIT);
    send_period(PERIOD_MAX);
    send_period(PERIOD_W'(131071));
    // refill after overflow keeps the old rpm until the next beat
    send_period(PERIOD_W'(1));
    send_period(PERIOD_W'(2));
    send_period(PERIOD_W'(3));
    send_period(PERIOD_W'(4));
    send_period(PERIOD_W'(5));

    // zero frequency divides to zero
    wait_drained();
    write_frequency('0);
    send_period(PERIOD_W'(7));
    send_period(PERIOD_W'(1));

    // largest frequency over a small window of one-tick periods gives a large rpm
    wait_drained();
    write_frequency(FREQ_MAX);
    send_period(PERIOD_W'(1));
    send_period(PERIOD_W'(1));
    send_period(PERIOD_W'(1));

    wait_drained();
    write_frequency(FREQ_W'(1));
    send_period(PERIOD_W'(1));
    send_period(PERIOD_W'(0));

    // random passes, each at its own frequency and idling mix
    wait_drained();
    write_frequency(FREQ_W'($urandom()));
    random_pass(RANDOM_PER_PASS);

    wait_drained();
    send_idle_pct = 78;
    recv_idle_pct = 17;
    write_frequency(FREQ_MAX);
    random_pass(RANDOM_PER_PASS);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_frequency(FREQ_W'($urandom()));
    random_pass(RANDOM_PER_PASS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/wprm_pkg.sv
src/wprm_window.sv
src/wprm_divider.sv
src/windowed_period_rpm_meter.sv
test/windowed_period_rpm_meter_tb.sv
